@@ rtl/icmp4_to_icmp6_header_translate_top_assert.svh @@
// ----------------------------------------------------------------------------
// icmp4_to_icmp6_header_translate_top_assert.svh
// Assertion macros used by the ICMP translation top module.
// ----------------------------------------------------------------------------
`ifndef ICMP4_TO_ICMP6_HEADER_TRANSLATE_TOP_ASSERT_SVH
`define ICMP4_TO_ICMP6_HEADER_TRANSLATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I46_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I46_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/i46_pkg.sv @@
// ----------------------------------------------------------------------------
// i46_pkg
// Types, message codes and the pointer table for ICMPv4 to ICMPv6 translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i46_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FALLBACK_MTU = 1'b0,
		CFG_IPV6_MIN_MTU = 1'b1
	} cfg_idx_t;

	localparam logic [15:0] FALLBACK_MTU_RST = 16'd1000;
	localparam logic [15:0] IPV6_MIN_MTU_RST = 16'd1280;

	// Header sizes
	localparam logic [15:0] IPV4_HDR_LEN = 16'd20;
	localparam logic [15:0] IPV6_HDR_LEN = 16'd40;
	localparam logic [31:0] MTU_ADJUST   = 32'd20;

	// ICMPv4 types
	localparam logic [7:0] ICMP4_PING_REPLY   = 8'd0;
	localparam logic [7:0] ICMP4_DEST_UNREACH = 8'd3;
	localparam logic [7:0] ICMP4_PING_REQ     = 8'd8;
	localparam logic [7:0] ICMP4_TIME_EXCEED  = 8'd11;
	localparam logic [7:0] ICMP4_PARAM_PROB   = 8'd12;

	// ICMPv4 destination unreachable codes
	localparam logic [7:0] UNR4_NET         = 8'd0;
	localparam logic [7:0] UNR4_HOST        = 8'd1;
	localparam logic [7:0] UNR4_PROTO       = 8'd2;
	localparam logic [7:0] UNR4_PORT        = 8'd3;
	localparam logic [7:0] UNR4_FRAG_NEEDED = 8'd4;
	localparam logic [7:0] UNR4_SRC_ROUTE   = 8'd5;
	localparam logic [7:0] UNR4_NET_UNKNOWN = 8'd6;
	localparam logic [7:0] UNR4_HOST_UNKN   = 8'd7;
	localparam logic [7:0] UNR4_ISOLATED    = 8'd8;
	localparam logic [7:0] UNR4_NET_PROHIB  = 8'd9;
	localparam logic [7:0] UNR4_HOST_PROHIB = 8'd10;
	localparam logic [7:0] UNR4_NET_TOS     = 8'd11;
	localparam logic [7:0] UNR4_HOST_TOS    = 8'd12;
	localparam logic [7:0] UNR4_ADMIN       = 8'd13;
	localparam logic [7:0] UNR4_PREC_CUTOFF = 8'd15;

	// ICMPv4 parameter problem codes
	localparam logic [7:0] PP4_POINTER    = 8'd0;
	localparam logic [7:0] PP4_BAD_LENGTH = 8'd2;

	// ICMPv6 types
	localparam logic [7:0] ICMP6_DEST_UNREACH = 8'd1;
	localparam logic [7:0] ICMP6_PKT_TOO_BIG  = 8'd2;
	localparam logic [7:0] ICMP6_TIME_EXCEED  = 8'd3;
	localparam logic [7:0] ICMP6_PARAM_PROB   = 8'd4;
	localparam logic [7:0] ICMP6_PING_REQ     = 8'd128;
	localparam logic [7:0] ICMP6_PING_REPLY   = 8'd129;

	// ICMPv6 codes
	localparam logic [7:0] UNR6_NO_ROUTE    = 8'd0;
	localparam logic [7:0] UNR6_ADMIN       = 8'd1;
	localparam logic [7:0] UNR6_PORT        = 8'd4;
	localparam logic [7:0] PTB6_CODE        = 8'd0;
	localparam logic [7:0] PP6_HDR_FIELD    = 8'd0;
	localparam logic [7:0] PP6_NEXT_HEADER  = 8'd1;

	// Pointer with no IPv6 counterpart
	localparam logic [7:0] PTR_NONE = 8'hff;

	typedef struct packed {
		logic [7:0]  icmp_type;
		logic [7:0]  icmp_code;
		logic [31:0] rest_word;
		logic [7:0]  ip_tos;
		logic [7:0]  ip_ttl;
		logic [15:0] ip_total_length;
	} i46_req_t;

	typedef struct packed {
		logic        drop;
		logic [7:0]  icmp6_type;
		logic [7:0]  icmp6_code;
		logic [31:0] new_rest_word;
		logic [7:0]  traffic_class;
		logic [7:0]  hops;
		logic [15:0] pay_len;
		logic        truncated;
	} i46_res_t;

	// IPv4 header byte offset to IPv6 header byte offset; anything past the
	// 20-byte header, or with no counterpart, yields PTR_NONE.
	function automatic logic [7:0] ptr_map(input logic [7:0] p);
		logic [7:0] m;
		case (p)
			8'd0:    m = 8'd0;
			8'd1:    m = 8'd1;
			8'd2:    m = 8'd4;
			8'd3:    m = 8'd4;
			8'd8:    m = 8'd7;
			8'd9:    m = 8'd6;
			8'd12:   m = 8'd8;
			8'd13:   m = 8'd8;
			8'd14:   m = 8'd8;
			8'd15:   m = 8'd8;
			8'd16:   m = 8'd24;
			8'd17:   m = 8'd24;
			8'd18:   m = 8'd24;
			8'd19:   m = 8'd24;
			default: m = PTR_NONE;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/icmp4_to_icmp6_header_translate_top.sv @@
// ----------------------------------------------------------------------------
// icmp4_to_icmp6_header_translate_top
// Stateless ICMPv4 to ICMPv6 header translation, one per clock unless stalled.
// ----------------------------------------------------------------------------
// Each request carries an ICMPv4 type, code and rest word with the outer TOS,
// TTL and total length; each gives exactly one result, held in the input
// register and then the result register. Unless res_stall holds both, a new
// request is taken every cycle: the block is an input register and a result
// register with the whole translation (a 32-bit add, a 17-bit compare and the
// pointer table) between them, so unstalled throughput is one request per
// cycle and stalls only back up from res_stall. Dropped messages return drop
// set and every other field zero. The user must write the MTU registers
// through cfg_we only while no request is in flight; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
`include "icmp4_to_icmp6_header_translate_top_assert.svh"

module icmp4_to_icmp6_header_translate_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [i46_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [i46_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            req_valid,
	output      logic                            req_stall,
	input  wire i46_pkg::i46_req_t               req,
	output      logic                            res_valid,
	input  wire logic                            res_stall,
	output      i46_pkg::i46_res_t               res
);
	import i46_pkg::*;

	logic [15:0] fallback_mtu_q;
	logic [15:0] ipv6_min_mtu_q;

	i46_req_t req_s1;
	logic     valid_s1;
	i46_res_t res_s2;
	logic     valid_s2;
	logic     adv_s1;
	logic     acc_req;

	i46_res_t res_c;
	logic     drop_c;
	logic [7:0]  type_c;
	logic [7:0]  code_c;
	logic [31:0] rest_c;
	logic [7:0]  ptr_c;
	logic [16:0] ipv6_len_c;
	logic        trunc_c;
	logic [15:0] plen_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_mtu_q <= FALLBACK_MTU_RST;
			ipv6_min_mtu_q <= IPV6_MIN_MTU_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FALLBACK_MTU: fallback_mtu_q <= cfg_wdata;
				CFG_IPV6_MIN_MTU: ipv6_min_mtu_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1    = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign acc_req   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_req) begin
			req_s1 <= req;
		end
	end

	// Type and code mapping
	always_comb begin
		drop_c = 1'b0;
		type_c = '0;
		code_c = '0;
		rest_c = req_s1.rest_word;
		ptr_c  = ptr_map(req_s1.rest_word[31:24]);
		case (req_s1.icmp_type)
			ICMP4_PING_REPLY: begin
				type_c = ICMP6_PING_REPLY;
				code_c = req_s1.icmp_code;
			end
			ICMP4_PING_REQ: begin
				type_c = ICMP6_PING_REQ;
				code_c = req_s1.icmp_code;
			end
			ICMP4_DEST_UNREACH: begin
				if (req_s1.icmp_code inside {UNR4_NET, UNR4_HOST, UNR4_SRC_ROUTE,
						UNR4_NET_UNKNOWN, UNR4_HOST_UNKN, UNR4_ISOLATED,
						UNR4_NET_TOS, UNR4_HOST_TOS}) begin
					type_c = ICMP6_DEST_UNREACH;
					code_c = UNR6_NO_ROUTE;
				end else if (req_s1.icmp_code inside {UNR4_NET_PROHIB,
						UNR4_HOST_PROHIB, UNR4_ADMIN, UNR4_PREC_CUTOFF}) begin
					type_c = ICMP6_DEST_UNREACH;
					code_c = UNR6_ADMIN;
				end else if (req_s1.icmp_code == UNR4_PORT) begin
					type_c = ICMP6_DEST_UNREACH;
					code_c = UNR6_PORT;
				end else if (req_s1.icmp_code == UNR4_PROTO) begin
					type_c = ICMP6_PARAM_PROB;
					code_c = PP6_NEXT_HEADER;
				end else if (req_s1.icmp_code == UNR4_FRAG_NEEDED) begin
					// MTU grows by the header size difference; zero means unknown
					type_c = ICMP6_PKT_TOO_BIG;
					code_c = PTB6_CODE;
					rest_c = (req_s1.rest_word != '0) ? req_s1.rest_word + MTU_ADJUST
						: {16'd0, fallback_mtu_q};
				end else begin
					drop_c = 1'b1;
				end
			end
			ICMP4_TIME_EXCEED: begin
				type_c = ICMP6_TIME_EXCEED;
				code_c = req_s1.icmp_code;
			end
			ICMP4_PARAM_PROB: begin
				// pointer past the IPv4 header or without counterpart drops
				if ((req_s1.icmp_code == PP4_POINTER || req_s1.icmp_code == PP4_BAD_LENGTH)
						&& ptr_c != PTR_NONE) begin
					type_c = ICMP6_PARAM_PROB;
					code_c = PP6_HDR_FIELD;
					rest_c = {24'd0, ptr_c};
				end else begin
					drop_c = 1'b1;
				end
			end
			default: drop_c = 1'b1;
		endcase
	end

	// Length and truncation
	always_comb begin
		ipv6_len_c = {1'b0, req_s1.ip_total_length} + {1'b0, IPV4_HDR_LEN};
		trunc_c    = ipv6_len_c > {1'b0, ipv6_min_mtu_q};
		if (trunc_c) begin
			plen_c = (ipv6_min_mtu_q >= IPV6_HDR_LEN) ? ipv6_min_mtu_q - IPV6_HDR_LEN : '0;
		end else begin
			plen_c = (req_s1.ip_total_length >= IPV4_HDR_LEN)
				? req_s1.ip_total_length - IPV4_HDR_LEN : '0;
		end
	end

	// Result assembly; a dropped message clears every other field
	always_comb begin
		res_c = '0;
		res_c.drop = drop_c;
		if (!drop_c) begin
			res_c.icmp6_type     = type_c;
			res_c.icmp6_code     = code_c;
			res_c.new_rest_word  = rest_c;
			res_c.traffic_class  = req_s1.ip_tos;
			res_c.hops           = req_s1.ip_ttl;
			res_c.pay_len        = plen_c;
			res_c.truncated      = trunc_c;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !res_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// Checks
	`I46_ASSERT_IMP(a_drop_clears, clk, arst_n, res_valid && res.drop,
		(res.icmp6_type == '0) && (res.new_rest_word == '0) && (res.pay_len == '0)
		&& !res.truncated, "dropped result carries non-zero fields")
	`I46_ASSERT_NXT(a_no_repeat, clk, arst_n, res_valid && !res_stall && !adv_s1,
		!res_valid, "result delivered twice")
	`I46_ASSERT_IMP(a_full_stalls, clk, arst_n, valid_s1 && valid_s2 && res_stall,
		req_stall, "request taken while both stages are held")
	`I46_ASSERT_NXT(a_accept_fills, clk, arst_n, acc_req, valid_s1,
		"accepted request lost before stage 1")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ICMPv4 to ICMPv6 header translator.
// ----------------------------------------------------------------------------
// A queue of ICMPv4 headers feeds a clocked driver. Each accepted request is
// translated by a predictor kept in the bench, and the expected ICMPv6 header
// waits in order until the monitor compares it field by field with the
// block's result. The run goes through several MTU settings, with random gaps
// on both sides, stretches without gaps, and one long output hold-off that
// fills the pipeline and backs up the input.
// ----------------------------------------------------------------------------

module testbench;

	import i46_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 80;
	localparam int STUCK_LIMIT = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	i46_req_t    req = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	i46_res_t    res;

	// Bench copy of the MTU registers
	logic [15:0] mtu_fallback = FALLBACK_MTU_RST;
	logic [15:0] mtu_floor6 = IPV6_MIN_MTU_RST;

	// IPv4 header offset to IPv6 header offset
	logic [7:0] v6_ptr_of [0:19] = '{
		8'd0, 8'd1, 8'd4, 8'd4, PTR_NONE,
		PTR_NONE, PTR_NONE, PTR_NONE, 8'd7, 8'd6,
		PTR_NONE, PTR_NONE, 8'd8, 8'd8, 8'd8,
		8'd8, 8'd24, 8'd24, 8'd24, 8'd24
	};

	i46_req_t icmp4_backlog [$];
	i46_res_t icmp6_due [$];

	bit idle_on = 1'b1;
	bit hold_start = 1'b0;
	bit req_taken = 1'b0;
	bit res_taken = 1'b0;
	int tx_gap = 0;
	int rx_wait = 0;
	int hold_cnt = 0;
	int stuck_cycles = 0;
	int err_count = 0;

	icmp4_to_icmp6_header_translate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Expected ICMPv6 header for one ICMPv4 request
	function automatic i46_res_t icmp6_of(i46_req_t h);
		i46_res_t    r;
		logic        dropped;
		logic [7:0]  ptr;
		logic [16:0] v6_len;
		r = '0;
		dropped = 1'b0;
		r.new_rest_word = h.rest_word;
		ptr = h.rest_word[31:24];
		case (h.icmp_type)
			ICMP4_PING_REPLY: begin
				r.icmp6_type = ICMP6_PING_REPLY;
				r.icmp6_code = h.icmp_code;
			end
			ICMP4_PING_REQ: begin
				r.icmp6_type = ICMP6_PING_REQ;
				r.icmp6_code = h.icmp_code;
			end
			ICMP4_DEST_UNREACH: begin
				case (h.icmp_code)
					UNR4_NET, UNR4_HOST, UNR4_SRC_ROUTE, UNR4_NET_UNKNOWN,
					UNR4_HOST_UNKN, UNR4_ISOLATED, UNR4_NET_TOS, UNR4_HOST_TOS: begin
						r.icmp6_type = ICMP6_DEST_UNREACH;
						r.icmp6_code = UNR6_NO_ROUTE;
					end
					UNR4_PROTO: begin
						r.icmp6_type = ICMP6_PARAM_PROB;
						r.icmp6_code = PP6_NEXT_HEADER;
					end
					UNR4_PORT: begin
						r.icmp6_type = ICMP6_DEST_UNREACH;
						r.icmp6_code = UNR6_PORT;
					end
					UNR4_FRAG_NEEDED: begin
						r.icmp6_type = ICMP6_PKT_TOO_BIG;
						r.icmp6_code = PTB6_CODE;
						// zero MTU advertised: report the fallback instead
						r.new_rest_word = (h.rest_word != '0) ? h.rest_word + MTU_ADJUST
							: {16'd0, mtu_fallback};
					end
					UNR4_NET_PROHIB, UNR4_HOST_PROHIB, UNR4_ADMIN, UNR4_PREC_CUTOFF: begin
						r.icmp6_type = ICMP6_DEST_UNREACH;
						r.icmp6_code = UNR6_ADMIN;
					end
					default: dropped = 1'b1;
				endcase
			end
			ICMP4_TIME_EXCEED: begin
				r.icmp6_type = ICMP6_TIME_EXCEED;
				r.icmp6_code = h.icmp_code;
			end
			ICMP4_PARAM_PROB: begin
				if (h.icmp_code == PP4_POINTER || h.icmp_code == PP4_BAD_LENGTH) begin
					// pointer past the IPv4 header or without a counterpart drops
					if (ptr >= 8'd20) begin
						dropped = 1'b1;
					end else if (v6_ptr_of[ptr] == PTR_NONE) begin
						dropped = 1'b1;
					end else begin
						r.icmp6_type = ICMP6_PARAM_PROB;
						r.icmp6_code = PP6_HDR_FIELD;
						r.new_rest_word = {24'd0, v6_ptr_of[ptr]};
					end
				end else begin
					dropped = 1'b1;
				end
			end
			default: dropped = 1'b1;
		endcase

		if (dropped) begin
			r = '0;
			r.drop = 1'b1;
			return r;
		end

		r.traffic_class = h.ip_tos;
		r.hops = h.ip_ttl;
		v6_len = {1'b0, h.ip_total_length} + {1'b0, IPV4_HDR_LEN};
		r.truncated = v6_len > {1'b0, mtu_floor6};
		if (r.truncated)
			r.pay_len = (mtu_floor6 >= IPV6_HDR_LEN) ? mtu_floor6 - IPV6_HDR_LEN : '0;
		else
			r.pay_len = (h.ip_total_length >= IPV4_HDR_LEN)
				? h.ip_total_length - IPV4_HDR_LEN : '0;
		return r;
	endfunction

	function automatic i46_req_t make_hdr(logic [7:0] t, logic [7:0] c, logic [31:0] rest,
		logic [7:0] tos, logic [7:0] ttl, logic [15:0] tlen);
		i46_req_t h;
		h.icmp_type = t;
		h.icmp_code = c;
		h.rest_word = rest;
		h.ip_tos = tos;
		h.ip_ttl = ttl;
		h.ip_total_length = tlen;
		return h;
	endfunction

	// Mostly translatable headers with random content, some noise
	function automatic i46_req_t random_hdr();
		i46_req_t h;
		int       pick;
		int       len;
		h.rest_word = $urandom;
		h.ip_tos = 8'($urandom);
		h.ip_ttl = 8'($urandom);
		h.icmp_code = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			h.icmp_type = ($urandom_range(0, 1) == 0) ? ICMP4_PING_REPLY : ICMP4_PING_REQ;
		end else if (pick < 45) begin
			h.icmp_type = ICMP4_DEST_UNREACH;
			if ($urandom_range(0, 99) < 85)
				h.icmp_code = 8'($urandom_range(0, 16));
			if (h.icmp_code == UNR4_FRAG_NEEDED) begin
				pick = $urandom_range(0, 9);
				if (pick < 2)
					h.rest_word = '0;
				else if (pick < 3)
					h.rest_word = 32'hffffffec + $urandom_range(0, 19);
			end
		end else if (pick < 55) begin
			h.icmp_type = ICMP4_TIME_EXCEED;
		end else if (pick < 80) begin
			h.icmp_type = ICMP4_PARAM_PROB;
			if ($urandom_range(0, 99) < 80)
				h.icmp_code = ($urandom_range(0, 1) == 0) ? PP4_POINTER : PP4_BAD_LENGTH;
			if ($urandom_range(0, 99) < 85)
				h.rest_word[31:24] = 8'($urandom_range(0, 23));
		end else begin
			h.icmp_type = 8'($urandom);
		end

		// lengths cluster around the truncation boundary
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			len = $urandom_range(20, 65535);
		end else if (pick < 80) begin
			len = int'(mtu_floor6) - 20 + $urandom_range(0, 6) - 3;
			if (len < 0)
				len = 0;
			if (len > 65535)
				len = 65535;
		end else if (pick < 95) begin
			len = $urandom_range(20, 1500);
		end else begin
			len = $urandom_range(0, 19);
		end
		h.ip_total_length = 16'(len);
		return h;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
		err_count++;
	endtask

	// Register write, only while nothing is in flight
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FALLBACK_MTU)
			mtu_fallback = val;
		else
			mtu_floor6 = val;
	endtask

	// Wait until every request has gone and every result has come back
	task automatic settle();
		while (icmp4_backlog.size() != 0 || req_valid || icmp6_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] fb, logic [15:0] floor6, int n, bit idle, bit hold);
		write_reg(CFG_FALLBACK_MTU, fb);
		write_reg(CFG_IPV6_MIN_MTU, floor6);
		idle_on = idle;
		for (int i = 0; i < n; i++)
			icmp4_backlog.push_back(random_hdr());
		if (hold)
			hold_start = 1'b1;
		settle();
	endtask

	// Request driver
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				req_valid <= 1'b0;
			end else if (icmp4_backlog.size() != 0) begin
				req <= icmp4_backlog.pop_front();
				req_valid <= 1'b1;
				tx_gap = idle_on ? $urandom_range(0, 4) : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side stall, with an occasional long hold-off
	always @(negedge clk) begin
		if (res_taken)
			rx_wait = idle_on ? $urandom_range(0, 4) : 0;
		if (hold_start) begin
			hold_cnt = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Monitor: predict on request, compare on result, watch for a hang
	always @(posedge clk) begin
		i46_res_t want;
		req_taken = arst_n && req_valid && !req_stall;
		res_taken = arst_n && res_valid && !res_stall;
		if (req_taken)
			icmp6_due.push_back(icmp6_of(req));
		if (res_taken) begin
			if (icmp6_due.size() == 0) begin
				report_mismatch("result with none expected", res.new_rest_word, '0);
			end else begin
				want = icmp6_due.pop_front();
				if (res.drop !== want.drop)
					report_mismatch("drop", 32'(res.drop), 32'(want.drop));
				if (res.icmp6_type !== want.icmp6_type)
					report_mismatch("icmp6_type", 32'(res.icmp6_type),
						32'(want.icmp6_type));
				if (res.icmp6_code !== want.icmp6_code)
					report_mismatch("icmp6_code", 32'(res.icmp6_code),
						32'(want.icmp6_code));
				if (res.new_rest_word !== want.new_rest_word)
					report_mismatch("new_rest_word", res.new_rest_word, want.new_rest_word);
				if (res.traffic_class !== want.traffic_class)
					report_mismatch("traffic_class", 32'(res.traffic_class),
						32'(want.traffic_class));
				if (res.hops !== want.hops)
					report_mismatch("hops", 32'(res.hops), 32'(want.hops));
				if (res.pay_len !== want.pay_len)
					report_mismatch("pay_len", 32'(res.pay_len), 32'(want.pay_len));
				if (res.truncated !== want.truncated)
					report_mismatch("truncated", 32'(res.truncated), 32'(want.truncated));
			end
		end
		if (req_taken || res_taken)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed headers at reset MTU settings
		icmp4_backlog.push_back(make_hdr(ICMP4_PING_REPLY, 8'h00, 32'h0, 8'hff, 8'h00, 16'd20));
		icmp4_backlog.push_back(make_hdr(ICMP4_PING_REQ, 8'hff, 32'hffffffff, 8'h00,
			8'hff, 16'hffff));
		for (int c = 0; c <= 15; c++)
			icmp4_backlog.push_back(make_hdr(ICMP4_DEST_UNREACH, 8'(c),
				(c == UNR4_FRAG_NEEDED) ? 32'h0 : 32'h12345678, 8'h5a, 8'ha5, 16'd1260));
		icmp4_backlog.push_back(make_hdr(ICMP4_DEST_UNREACH, UNR4_FRAG_NEEDED, 32'hffffffff,
			8'h01, 8'h40, 16'd1261));
		icmp4_backlog.push_back(make_hdr(ICMP4_DEST_UNREACH, 8'hff, 32'h1, 8'h02, 8'h40, 16'd64));
		icmp4_backlog.push_back(make_hdr(ICMP4_TIME_EXCEED, 8'h01, 32'h0, 8'h03, 8'h01, 16'd5));
		// no IPv6 counterpart, last mapped offset, past the header, bad code
		icmp4_backlog.push_back(make_hdr(ICMP4_PARAM_PROB, PP4_POINTER, 32'h04000000,
			8'h04, 8'h02, 16'd100));
		icmp4_backlog.push_back(make_hdr(ICMP4_PARAM_PROB, PP4_BAD_LENGTH, 32'h13abcdef,
			8'h05, 8'h03, 16'd0));
		icmp4_backlog.push_back(make_hdr(ICMP4_PARAM_PROB, PP4_POINTER, 32'h14000000,
			8'h06, 8'h04, 16'd100));
		icmp4_backlog.push_back(make_hdr(ICMP4_PARAM_PROB, 8'h01, 32'h00000000,
			8'h07, 8'h05, 16'd100));
		icmp4_backlog.push_back(make_hdr(8'hff, 8'h00, 32'h0, 8'h08, 8'h06, 16'd100));
		settle();

		run_phase(16'd0, 16'd1280, 120, 1'b1, 1'b0);
		run_phase(16'hffff, 16'hffff, 120, 1'b0, 1'b0);
		run_phase(16'($urandom), 16'($urandom_range(1280, 65535)), 120, 1'b1, 1'b0);
		// minimum MTU below the IPv6 header size
		run_phase(16'd1, 16'd36, 60, 1'b1, 1'b0);
		run_phase(16'($urandom), 16'd1300, 100, 1'b1, 1'b1);
		run_phase(FALLBACK_MTU_RST, IPV6_MIN_MTU_RST, 100, 1'b0, 1'b0);

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ icmp4_to_icmp6_header_translate_top.f @@
+incdir+rtl
rtl/i46_pkg.sv
rtl/icmp4_to_icmp6_header_translate_top.sv
verif/testbench.sv
